// ----- hdl/tlptw_pkg.sv -----
package tlptw_pkg;

  localparam int unsigned AddrW = 64;
  localparam int unsigned CfgIdxW = 1;

  localparam logic ActNewReq = 1'b0;
  localparam logic ActPteData = 1'b1;

  localparam logic ResReadReq = 1'b0;
  localparam logic ResOutcome = 1'b1;

  localparam logic [1:0] AccRead = 2'd0;
  localparam logic [1:0] AccWrite = 2'd1;
  localparam logic [1:0] AccExec = 2'd2;

  localparam logic [2:0] CauseNone = 3'd0;
  localparam logic [2:0] CauseExecMisalign = 3'd1;
  localparam logic [2:0] CauseNotPresent = 3'd2;
  localparam logic [2:0] CausePerm = 3'd3;
  localparam logic [2:0] CauseReserved = 3'd4;
  localparam logic [2:0] CauseNonCanon = 3'd5;

  localparam logic [2:0] SubNone = 3'd0;
  localparam logic [2:0] SubNoValid = 3'd1;
  localparam logic [2:0] SubPerm = 3'd2;
  localparam logic [2:0] SubReserved = 3'd3;
  localparam logic [2:0] SubCanon = 3'd4;

  localparam logic [1:0] Lvl0 = 2'd0;
  localparam logic [1:0] Lvl1 = 2'd1;
  localparam logic [1:0] Lvl2 = 2'd2;

  localparam logic [CfgIdxW-1:0] CfgPagingEn = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgRootBase = 1'b1;

  localparam int unsigned PteV = 0;
  localparam int unsigned PteR = 1;
  localparam int unsigned PteW = 2;
  localparam int unsigned PteX = 3;
  localparam int unsigned PteU = 4;

  typedef struct packed {
    logic             action;
    logic [AddrW-1:0] vaddr;
    logic [1:0]       access_kind;
    logic             user_access;
    logic [AddrW-1:0] entry_data;
  } in_req_t;

  typedef struct packed {
    logic             result_kind;
    logic [AddrW-1:0] read_address;
    logic             success;
    logic [AddrW-1:0] physical_addr;
    logic [2:0]       fault_cause;
    logic [2:0]       fault_subtype;
    logic [1:0]       fault_level;
  } out_res_t;

endpackage

// ----- hdl/three_level_page_table_walker_top.sv -----
// an accepted request's result is registered and shows in the cycle after it is accepted
// throughput: one request per cycle while out_ready stays high, set by the single result register
// a returned entry while no walk is open is taken and gives no result
// reset (synchronous, rst_n low): walker idle at level 2, paging off, root base 0,
// result register empty
module three_level_page_table_walker_top
  import tlptw_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  in_req_t            in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output out_res_t           out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [AddrW-1:0]   cfg_data
);

  logic             paging_en_r;
  logic [AddrW-1:0] root_base_r;
  logic             busy_r, busy_nxt;
  logic [1:0]       level_r, level_nxt;
  logic [AddrW-1:0] held_va_r, held_va_nxt;
  logic [1:0]       held_acc_r, held_acc_nxt;
  logic             held_user_r, held_user_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_res_t         out_data_r, out_data_nxt;
  logic             accept;

  function automatic out_res_t fault_res(logic [2:0] cause, logic [2:0] sub,
                                         logic [1:0] lvl);
    out_res_t r;
    r = '0;
    r.result_kind = ResOutcome;
    r.fault_cause = cause;
    r.fault_subtype = sub;
    r.fault_level = lvl;
    return r;
  endfunction

  function automatic out_res_t ok_res(logic [AddrW-1:0] pa);
    out_res_t r;
    r = '0;
    r.result_kind = ResOutcome;
    r.success = 1'b1;
    r.physical_addr = pa;
    return r;
  endfunction

  function automatic out_res_t read_res(logic [AddrW-1:0] addr);
    out_res_t r;
    r = '0;
    r.result_kind = ResReadReq;
    r.read_address = addr;
    return r;
  endfunction

  function automatic logic [8:0] va_index(logic [AddrW-1:0] va, logic [1:0] lvl);
    logic [8:0] idx;
    case (lvl)
      Lvl0:    idx = va[20:12];
      Lvl1:    idx = va[29:21];
      default: idx = va[38:30];
    endcase
    return idx;
  endfunction

  assign accept = in_valid && in_ready;
  assign in_ready = !out_valid_r || out_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

  always_comb begin
    logic [AddrW-1:0] va;
    logic [AddrW-1:0] pte;
    logic [AddrW-1:0] pte_base;
    logic [AddrW-1:0] off;
    logic [1:0]       lvl;
    logic             canon;
    logic             rwx;
    logic             rsvd;
    logic             allowed;
    va = in_data.vaddr;
    pte = in_data.entry_data;
    pte_base = {pte[61:10], 12'h000};
    lvl = (level_r > Lvl2) ? Lvl2 : level_r;
    canon = (va[63:38] == '0) || (va[63:38] == '1);
    rwx = pte[PteR] || pte[PteW] || pte[PteX];
    rsvd = (pte[63:54] != '0);
    case (lvl)
      Lvl0:    off = {52'd0, held_va_r[11:0]};
      Lvl1:    off = {43'd0, held_va_r[20:0]};
      default: off = {34'd0, held_va_r[29:0]};
    endcase
    case (held_acc_r)
      AccRead:  allowed = pte[PteR];
      AccWrite: allowed = pte[PteW];
      AccExec:  allowed = pte[PteX];
      default:  allowed = 1'b0;
    endcase
    if (held_user_r && !pte[PteU]) begin
      allowed = 1'b0;
    end

    busy_nxt = busy_r;
    level_nxt = level_r;
    held_va_nxt = held_va_r;
    held_acc_nxt = held_acc_r;
    held_user_nxt = held_user_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt = out_data_r;

    if (accept) begin
      out_valid_nxt = 1'b1;
      if (in_data.action == ActNewReq) begin
        busy_nxt = 1'b0;
        level_nxt = Lvl2;
        if (in_data.access_kind == AccExec && va[0]) begin
          out_data_nxt = fault_res(CauseExecMisalign, SubNone, Lvl0);
        end else if (!paging_en_r) begin
          out_data_nxt = ok_res(va);
        end else if (root_base_r[11:0] != '0) begin
          out_data_nxt = fault_res(CauseReserved, SubReserved, Lvl2);
        end else if (!canon) begin
          out_data_nxt = fault_res(CauseNonCanon, SubCanon, Lvl2);
        end else begin
          held_va_nxt = va;
          held_acc_nxt = in_data.access_kind;
          held_user_nxt = in_data.user_access;
          busy_nxt = 1'b1;
          out_data_nxt = read_res(root_base_r + {52'd0, va[38:30], 3'b000});
        end
      end else if (!busy_r) begin
        out_valid_nxt = out_valid_r && !out_ready;
      end else begin
        busy_nxt = 1'b0;
        level_nxt = Lvl2;
        if (!pte[PteV]) begin
          out_data_nxt = fault_res(CauseNotPresent, SubNoValid, lvl);
        end else if (lvl == Lvl0 && rsvd) begin
          out_data_nxt = fault_res(CauseReserved, SubReserved, Lvl0);
        end else if (lvl == Lvl0 || rwx) begin
          // leaf
          if (!rwx) begin
            out_data_nxt = fault_res(CauseNotPresent, SubNoValid, lvl);
          end else if (!allowed) begin
            out_data_nxt = fault_res(CausePerm, SubPerm, lvl);
          end else begin
            out_data_nxt = ok_res(pte_base + off);
          end
        end else if (rsvd) begin
          out_data_nxt = fault_res(CauseReserved, SubReserved, lvl);
        end else begin
          busy_nxt = 1'b1;
          level_nxt = lvl - 2'd1;
          out_data_nxt = read_res(pte_base +
                                  {52'd0, va_index(held_va_r, lvl - 2'd1), 3'b000});
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      paging_en_r <= 1'b0;
      root_base_r <= '0;
      busy_r <= 1'b0;
      level_r <= Lvl2;
      held_va_r <= '0;
      held_acc_r <= AccRead;
      held_user_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CfgPagingEn: paging_en_r <= cfg_data[0];
          CfgRootBase: root_base_r <= cfg_data;
          default: ;
        endcase
      end
      busy_r <= busy_nxt;
      level_r <= level_nxt;
      held_va_r <= held_va_nxt;
      held_acc_r <= held_acc_nxt;
      held_user_r <= held_user_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

endmodule
